>>> design/address_comment_stripper_assert.svh
// Assertion macros for the address comment stripper.
// Used by the top level; needs clk and rst in the scope of each use.
`ifndef ADDRESS_COMMENT_STRIPPER_ASSERT_SVH
`define ADDRESS_COMMENT_STRIPPER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ACS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ACS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/acs_pkg.sv
// Shared types and constants for the address comment stripper.
// No dependencies; used by acs_parse, acs_out_buf and the top level.
package acs_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_DISCARD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // Status codes carried in the end word.
  localparam logic [3:0] STAT_OK             = 4'd0;
  localparam logic [3:0] STAT_OPEN_COMMENT   = 4'd1;
  localparam logic [3:0] STAT_STRAY_PAREN    = 4'd2;
  localparam logic [3:0] STAT_OPEN_QUOTE     = 4'd3;
  localparam logic [3:0] STAT_OPEN_ANGLE     = 4'd4;
  localparam logic [3:0] STAT_NESTED_ANGLE   = 4'd5;
  localparam logic [3:0] STAT_STRAY_ANGLE    = 4'd6;
  localparam logic [3:0] STAT_TRAIL_BSLASH   = 4'd7;
  localparam logic [3:0] STAT_TOO_DEEP       = 4'd8;

  // Characters with a special meaning.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // One result word.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [3:0] status;
    logic       end_mark;
  } acs_res_t;

  // Results of one input byte, handed from the parser to the result buffer.
  typedef struct packed {
    logic [1:0] count;
    acs_res_t   first;
    acs_res_t   second;
  } acs_push_t;

endpackage

>>> design/acs_if.sv
// Valid/ready channel interfaces for the address comment stripper.
// No dependencies.
interface acs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface acs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [3:0] status;
  logic       end_mark;

  modport source (output valid, output kind, output out_byte, output status,
                  output end_mark, input ready);
  modport sink   (input valid, input kind, input out_byte, input status,
                  input end_mark, output ready);
endinterface

>>> design/acs_parse.sv
// Parser state and per-byte decode for the address comment stripper.
// Depends on acs_pkg.
module acs_parse #(
  parameter int MAX_COMMENT_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          b,
  input  logic                last,
  output acs_pkg::acs_push_t  push
);

  localparam int DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);

  logic               quote_mode, quote_mode_next;
  logic               angle_open, angle_open_next;
  logic               output_finished, output_finished_next;
  logic [3:0]         error_status, error_status_next;
  logic               escape_pending, escape_pending_next;
  logic [DEPTH_W-1:0] comment_depth, comment_depth_next;
  logic               comment_quote, comment_quote_next;
  logic               comment_escape, comment_escape_next;

  logic               first_vld;
  acs_pkg::acs_res_t  first_res;
  acs_pkg::acs_res_t  end_res;
  logic [3:0]         end_status;

  // Decode of one byte against the current state.
  always_comb begin
    quote_mode_next      = quote_mode;
    angle_open_next      = angle_open;
    output_finished_next = output_finished;
    error_status_next    = error_status;
    escape_pending_next  = escape_pending;
    comment_depth_next   = comment_depth;
    comment_quote_next   = comment_quote;
    comment_escape_next  = comment_escape;
    first_vld            = 1'b0;
    first_res            = '{kind: acs_pkg::KIND_DATA, out_byte: b,
                             status: acs_pkg::STAT_OK, end_mark: 1'b0};

    if (error_status == acs_pkg::STAT_OK && !output_finished) begin
      if (comment_depth != '0) begin
        if (comment_escape) begin
          comment_escape_next = 1'b0;
        end else if (comment_quote) begin
          if (b == acs_pkg::CH_QUOTE) begin
            comment_quote_next = 1'b0;
          end else if (b == acs_pkg::CH_BSLASH) begin
            comment_escape_next = 1'b1;
          end
        end else if (b == acs_pkg::CH_CLOSE) begin
          comment_depth_next = comment_depth - DEPTH_W'(1);
          if (comment_depth == DEPTH_W'(1)) begin
            // Closing the outermost comment leaves a single space.
            first_vld          = 1'b1;
            first_res.out_byte = acs_pkg::CH_SPACE;
          end
        end else if (b == acs_pkg::CH_OPEN) begin
          if (comment_depth >= DEPTH_W'(MAX_COMMENT_DEPTH)) begin
            error_status_next = acs_pkg::STAT_TOO_DEEP;
          end else begin
            comment_depth_next = comment_depth + DEPTH_W'(1);
          end
        end else if (b == acs_pkg::CH_BSLASH) begin
          comment_escape_next = 1'b1;
        end else if (b == acs_pkg::CH_QUOTE) begin
          comment_quote_next = 1'b1;
        end
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        first_vld           = 1'b1;
      end else if (b == acs_pkg::CH_BSLASH) begin
        if (last) begin
          error_status_next = acs_pkg::STAT_TRAIL_BSLASH;
        end else begin
          escape_pending_next = 1'b1;
          first_vld           = 1'b1;
        end
      end else if (b == acs_pkg::CH_QUOTE) begin
        quote_mode_next = ~quote_mode;
        first_vld       = 1'b1;
      end else if (quote_mode) begin
        first_vld = 1'b1;
      end else if (b == acs_pkg::CH_OPEN) begin
        comment_depth_next  = DEPTH_W'(1);
        comment_quote_next  = 1'b0;
        comment_escape_next = 1'b0;
      end else if (b == acs_pkg::CH_CLOSE) begin
        error_status_next = acs_pkg::STAT_STRAY_PAREN;
      end else if (b == acs_pkg::CH_LT) begin
        if (angle_open) begin
          error_status_next = acs_pkg::STAT_NESTED_ANGLE;
        end else begin
          angle_open_next    = 1'b1;
          first_vld          = 1'b1;
          first_res.kind     = acs_pkg::KIND_DISCARD;
          first_res.out_byte = '0;
        end
      end else if (b == acs_pkg::CH_GT) begin
        if (angle_open) begin
          output_finished_next = 1'b1;
        end else begin
          error_status_next = acs_pkg::STAT_STRAY_ANGLE;
        end
      end else begin
        first_vld = 1'b1;
      end
    end

    // Status of the string as it stands after this byte.
    if (error_status_next != acs_pkg::STAT_OK) begin
      end_status = error_status_next;
    end else if (output_finished_next) begin
      end_status = acs_pkg::STAT_OK;
    end else if (comment_depth_next != '0) begin
      end_status = acs_pkg::STAT_OPEN_COMMENT;
    end else if (quote_mode_next) begin
      end_status = acs_pkg::STAT_OPEN_QUOTE;
    end else if (angle_open_next) begin
      end_status = acs_pkg::STAT_OPEN_ANGLE;
    end else begin
      end_status = acs_pkg::STAT_OK;
    end
    end_res = '{kind: acs_pkg::KIND_END, out_byte: 8'h00,
                status: end_status, end_mark: 1'b1};

    // The last byte returns every flag to its reset value.
    if (last) begin
      quote_mode_next      = 1'b0;
      angle_open_next      = 1'b0;
      output_finished_next = 1'b0;
      error_status_next    = acs_pkg::STAT_OK;
      escape_pending_next  = 1'b0;
      comment_depth_next   = '0;
      comment_quote_next   = 1'b0;
      comment_escape_next  = 1'b0;
    end
  end

  // Pack the results: a data or discard word, if any, precedes the end word.
  always_comb begin
    push.count  = 2'(first_vld) + 2'(last);
    push.first  = first_vld ? first_res : end_res;
    push.second = end_res;
  end

  // State registers, updated once per consumed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode      <= 1'b0;
      angle_open      <= 1'b0;
      output_finished <= 1'b0;
      error_status    <= acs_pkg::STAT_OK;
      escape_pending  <= 1'b0;
      comment_depth   <= '0;
      comment_quote   <= 1'b0;
      comment_escape  <= 1'b0;
    end else if (fire) begin
      quote_mode      <= quote_mode_next;
      angle_open      <= angle_open_next;
      output_finished <= output_finished_next;
      error_status    <= error_status_next;
      escape_pending  <= escape_pending_next;
      comment_depth   <= comment_depth_next;
      comment_quote   <= comment_quote_next;
      comment_escape  <= comment_escape_next;
    end
  end

endmodule

>>> design/acs_out_buf.sv
// Two-word result buffer that drives the output channel.
// Depends on acs_pkg and acs_out_if.
module acs_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  acs_pkg::acs_push_t push,
  output logic               can_push,
  acs_out_if.source          result_stream
);

  logic [1:0]        cnt;
  acs_pkg::acs_res_t slot0;
  acs_pkg::acs_res_t slot1;
  logic              pop;

  // The buffer takes a new group only when it will be empty after this edge.
  assign pop      = result_stream.valid && result_stream.ready;
  assign can_push = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  assign result_stream.valid    = (cnt != 2'd0);
  assign result_stream.kind     = slot0.kind;
  assign result_stream.out_byte = slot0.out_byte;
  assign result_stream.status   = slot0.status;
  assign result_stream.end_mark = slot0.end_mark;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (fire) begin
      cnt <= push.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Word slots; the second moves forward when the first is taken.
  always_ff @(posedge clk) begin
    if (fire) begin
      slot0 <= push.first;
      slot1 <= push.second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

>>> design/address_comment_stripper.sv
// Address comment stripper: top level with the input register.
// Depends on acs_pkg, acs_if, acs_parse, acs_out_buf and the assertion header.
//
// Usage: char_stream carries one address byte per word with last_byte set on
// the final byte of a string. result_stream carries data bytes (comments are
// replaced by one space), a discard word for an open angle bracket, and on
// the last byte an end word with end_mark set and the status.
// An accepted byte is held in the input register and decoded from there; its
// result words are written into the result buffer, which offers them on
// result_stream.
// Throughput: one byte per cycle while the receiver is ready and each byte
// yields at most one word; a last byte that also yields a data or discard word
// holds the input back until the two-word result buffer drains, one word per cycle.
// Reset (rst, synchronous) clears all parser flags, the comment depth, the
// input register and the result buffer; no clearing pass is needed.
// When the receiver stalls, the result buffer holds its words, the input
// register holds one byte, and char_stream.ready falls once the buffer cannot take it.
module address_comment_stripper #(
  parameter int MAX_COMMENT_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  acs_in_if.sink     char_stream,
  acs_out_if.source  result_stream
);

  logic               in_vld;
  logic [7:0]         in_byte_q;
  logic               in_last_q;
  logic               fire;
  logic               can_push;
  acs_pkg::acs_push_t push;

  assign fire              = in_vld && can_push;
  assign char_stream.ready = !in_vld || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (char_stream.valid && char_stream.ready) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_stream.valid && char_stream.ready) begin
      in_byte_q <= char_stream.in_byte;
      in_last_q <= char_stream.last_byte;
    end
  end

  acs_parse #(
    .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .b    (in_byte_q),
    .last (in_last_q),
    .push (push)
  );

  acs_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .push          (push),
    .can_push      (can_push),
    .result_stream (result_stream)
  );

  // Checks on the block's own logic.
`include "address_comment_stripper_assert.svh"

  `ACS_ASSERT_NOW(a_two_words_end, fire && push.count == 2'd2, push.second.end_mark && push.first.end_mark == 1'b0, "second word of a pair is not the end word")
  `ACS_ASSERT_NOW(a_end_kind, result_stream.valid && result_stream.end_mark, result_stream.kind == acs_pkg::KIND_END, "end word with wrong kind")
  `ACS_ASSERT_NOW(a_count_last, fire, (push.count != 2'd0) || !in_last_q, "last byte gave no end word")
  `ACS_ASSERT_NEXT(a_hold_byte, in_vld && !fire, in_vld && $stable(in_byte_q), "held input byte lost")

endmodule
